>>> hdl/qalu_pkg.sv
// Shared constants, types and the Hamilton product sign table of the quaternion ALU.
package qalu_pkg;

  localparam int CW = 16;          // component width
  localparam int FB = 12;          // fraction bits
  localparam int PW = 2 * CW;      // product width
  localparam int SW = PW + 2;      // sum of four products
  localparam int DW = PW + 1;      // squared norm, unsigned
  localparam int NW = SW + FB;     // scaled dividend magnitude
  localparam int QB = CW + 1;      // quotient bits resolved by the divider

  typedef logic signed [CW-1:0] comp_t;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Term j of result component i is a[j]*b[i^j]; this bit marks a subtracted term.
  localparam logic [3:0][3:0] HNEG = '{
    4'b0100,   // component 3: terms 0..3 = +,+,-,+ (bit j)
    4'b0010,   // component 2: +,-,+,+
    4'b1000,   // component 1: +,+,+,-
    4'b1110    // component 0: +,-,-,-
  };

  // Control word that travels alongside each item through the pipeline
  typedef struct packed {
    logic    v;
    action_t act;
    logic    divz;
  } ctl_t;

endpackage

>>> hdl/quaternion_alu.sv
// Quaternion ALU: fully pipelined add, subtract, Hamilton product and divide.
//
// Usage: drive action and the operands a_* and b_* with start high for one
// cycle; the word is taken at that edge. busy is always low, so a new word may
// be started every cycle. Each result appears on r_* and status for exactly one
// cycle with strobe high, in issue order. Throughput is one word per cycle:
// three stages form the products, sums and magnitudes, then seventeen stages
// each resolve one quotient bit of the restoring divider (one per component),
// and a final stage negates, clamps and drives the outputs. All operations
// take the same path so latency is fixed.
// status: ST_OK, ST_DIVZ (|b|^2 zero, components zero) or ST_SAT (a component
// was clamped). Division truncates toward zero.
// Reset (rst, synchronous) clears the valid bits of every stage; words in
// flight are dropped. The receiver cannot stall, so no backpressure exists.
module quaternion_alu
  import qalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  comp_t       a_w,
  input  comp_t       a_x,
  input  comp_t       a_y,
  input  comp_t       a_z,
  input  comp_t       b_w,
  input  comp_t       b_x,
  input  comp_t       b_y,
  input  comp_t       b_z,
  output logic        strobe,
  output comp_t       r_w,
  output comp_t       r_x,
  output comp_t       r_y,
  output comp_t       r_z,
  output logic [1:0]  status
);

  comp_t a_in [4];
  comp_t b_in [4];

  // stage 1: products, squares and add/subtract results
  ctl_t                    c1;
  logic signed [PW-1:0]    p1 [4][4];
  logic [PW-1:0]           sq1 [4];
  logic signed [CW:0]      as1 [4];

  // stage 2: sums and squared norm
  ctl_t                    c2;
  logic signed [SW-1:0]    r2 [4];
  logic [DW-1:0]           den2;

  // stage 3 and divider stages
  ctl_t                    cd   [QB+1];
  logic [DW-1:0]           dend [QB+1];
  logic                    negd [4][QB+1];
  logic                    psat [4][QB+1];  // quotient certain to overflow
  comp_t                   resd [4][QB+1];  // finished non-divide result
  logic                    satd [4][QB+1];
  logic [DW-1:0]           remd [4][QB+1];
  logic [QB-1:0]           qd   [4][QB+1];
  logic [QB-1:0]           nlo  [4][QB+1];

  assign a_in[0] = a_w;  assign a_in[1] = a_x;
  assign a_in[2] = a_y;  assign a_in[3] = a_z;
  assign b_in[0] = b_w;  assign b_in[1] = b_x;
  assign b_in[2] = b_y;  assign b_in[3] = b_z;

  assign busy = 1'b0;

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      c1.v <= 1'b0;
    end else begin
      c1.v <= start;
    end
    c1.act  <= action_t'(action);
    c1.divz <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1[i][j] <= a_in[i] * b_in[j];
      end
      sq1[i] <= b_in[i] * b_in[i];
      if (action_t'(action) == ACT_SUB) begin
        as1[i] <= (CW+1)'(a_in[i]) - (CW+1)'(b_in[i]);
      end else begin
        as1[i] <= (CW+1)'(a_in[i]) + (CW+1)'(b_in[i]);
      end
    end
  end

  // stage 2: signed sums of four terms or the add/sub result, and the squared norm
  logic signed [SW-1:0] sum_c [4];
  logic [DW-1:0]        den_c;

  always_comb begin
    logic tneg;
    den_c = '0;
    for (int i = 0; i < 4; i++) begin
      den_c = den_c + DW'(sq1[i]);
    end
    for (int i = 0; i < 4; i++) begin
      sum_c[i] = '0;
      for (int j = 0; j < 4; j++) begin
        // divide uses conj(b): every term with a vector part of b flips sign
        tneg = HNEG[i][j] ^ ((c1.act == ACT_DIV) && ((i ^ j) != 0));
        if (tneg) begin
          sum_c[i] = sum_c[i] - SW'(p1[j][i ^ j]);
        end else begin
          sum_c[i] = sum_c[i] + SW'(p1[j][i ^ j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2.v <= 1'b0;
    end else begin
      c2.v <= c1.v;
    end
    c2.act  <= c1.act;
    c2.divz <= (c1.act == ACT_DIV) && (den_c == '0);
    den2    <= den_c;
    for (int i = 0; i < 4; i++) begin
      if (c1.act == ACT_ADD || c1.act == ACT_SUB) begin
        r2[i] <= SW'(as1[i]);
      end else begin
        r2[i] <= sum_c[i];
      end
    end
  end

  // stage 3: magnitude, scaling and clamp of non-divide results, divider set-up
  logic [SW-1:0] mag3 [4];
  logic [SW-1:0] val3 [4];
  logic [SW-1:0] lim3 [4];
  logic [NW-1:0] num3 [4];
  logic [NW-1:0] top3 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag3[i] = r2[i][SW-1] ? SW'(-r2[i]) : SW'(r2[i]);
      val3[i] = (c2.act == ACT_MUL) ? (mag3[i] >> FB) : mag3[i];
      lim3[i] = r2[i][SW-1] ? (SW'(1) << (CW-1)) : ((SW'(1) << (CW-1)) - SW'(1));
      num3[i] = NW'(mag3[i]) << FB;
      top3[i] = num3[i] >> QB;
    end
  end

  // divider: each stage brings down one dividend bit and resolves one quotient bit
  logic [DW:0]   trial [4][QB];
  logic          ge    [4][QB];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      for (int i = 0; i < 4; i++) begin
        trial[i][k] = {remd[i][k], nlo[i][k][QB-1-k]};
        ge[i][k]    = (trial[i][k] >= {1'b0, dend[k]});
      end
    end
  end

  // stage 3 registers and the divider stages
  always_ff @(posedge clk) begin
    logic [SW-1:0] cv;
    if (rst) begin
      cd[0].v <= 1'b0;
    end else begin
      cd[0].v <= c2.v;
    end
    cd[0].act  <= c2.act;
    cd[0].divz <= c2.divz;
    dend[0]    <= den2;
    for (int i = 0; i < 4; i++) begin
      cv = (val3[i] > lim3[i]) ? lim3[i] : val3[i];
      negd[i][0] <= r2[i][SW-1];
      satd[i][0] <= (val3[i] > lim3[i]);
      resd[i][0] <= r2[i][SW-1] ? comp_t'(CW'(-cv)) : comp_t'(CW'(cv));
      psat[i][0] <= (top3[i] >= NW'(den2));
      remd[i][0] <= DW'(top3[i]);
      nlo[i][0]  <= num3[i][QB-1:0];
      qd[i][0]   <= '0;
    end
    for (int k = 0; k < QB; k++) begin
      if (rst) begin
        cd[k+1].v <= 1'b0;
      end else begin
        cd[k+1].v <= cd[k].v;
      end
      cd[k+1].act  <= cd[k].act;
      cd[k+1].divz <= cd[k].divz;
      dend[k+1]    <= dend[k];
      for (int i = 0; i < 4; i++) begin
        negd[i][k+1] <= negd[i][k];
        satd[i][k+1] <= satd[i][k];
        resd[i][k+1] <= resd[i][k];
        psat[i][k+1] <= psat[i][k];
        nlo[i][k+1]  <= nlo[i][k];
        qd[i][k+1]   <= {qd[i][k][QB-2:0], ge[i][k]};
        remd[i][k+1] <= ge[i][k] ? DW'(trial[i][k] - {1'b0, dend[k]}) : DW'(trial[i][k]);
      end
    end
  end

  // final stage: clamp and sign the quotient, pick the result, drive the word
  comp_t      fin   [4];
  logic [3:0] fsat;

  always_comb begin
    logic [QB-1:0] lim;
    logic [QB-1:0] qm;
    for (int i = 0; i < 4; i++) begin
      lim = negd[i][QB] ? (QB'(1) << (CW-1)) : ((QB'(1) << (CW-1)) - QB'(1));
      if (cd[QB].act == ACT_DIV) begin
        fsat[i] = psat[i][QB] || (qd[i][QB] > lim);
        qm      = fsat[i] ? lim : qd[i][QB];
        fin[i]  = negd[i][QB] ? comp_t'(CW'(-qm)) : comp_t'(CW'(qm));
      end else begin
        fsat[i] = satd[i][QB];
        qm      = '0;
        fin[i]  = resd[i][QB];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cd[QB].v;
    end
    if (cd[QB].divz) begin
      r_w    <= '0;
      r_x    <= '0;
      r_y    <= '0;
      r_z    <= '0;
      status <= ST_DIVZ;
    end else begin
      r_w    <= fin[0];
      r_x    <= fin[1];
      r_y    <= fin[2];
      r_z    <= fin[3];
      status <= (fsat != '0) ? ST_SAT : ST_OK;
    end
  end

endmodule
